// ===== sv/fsmatch_pkg.sv =====
// Shared types and constants for the first-substring-match block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fsmatch_pkg;

  // Capacity of the pattern and of the window of recent haystack bytes.
  localparam int MaxPattern = 64;
  // Width of the saturating haystack byte counter.
  localparam int CountBits  = 32;
  // Widths that follow from the field definitions and the constants above.
  localparam int ByteW      = 8;
  localparam int PosW       = 32;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int ExtW0      = (CountBits > PosW) ? CountBits : PosW;
  localparam int ExtW       = (ExtW0 > LenW) ? ExtW0 : LenW;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_HAY    = 2'd2,
    REQ_END    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EVAL = 1'b1
  } fsm_state_e;

  // Per-cycle commands broadcast to every cell of the comparator row.
  typedef struct packed {
    logic pat_shift;  // shift a pattern byte in at the newest end
    logic act_clear;  // mark every pattern slot empty
    logic win_shift;  // shift a haystack byte in at the newest end
    logic win_clear;  // zero the window
  } cell_ctrl_t;

endpackage : fsmatch_pkg

`default_nettype wire

// ===== sv/fsmatch_cell.sv =====
// One comparator cell: holds a pattern byte, its in-use flag and a window byte.
// Depends on fsmatch_pkg; chained by fsmatch_row.
`timescale 1ns / 1ps
`default_nettype none

module fsmatch_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire fsmatch_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]              pat_i,
  input  wire logic                    act_i,
  input  wire logic [7:0]              win_i,
  output logic [7:0]                   pat_o,
  output logic                         act_o,
  output logic [7:0]                   win_o,
  output logic                         hit_o
);
  import fsmatch_pkg::*;

  logic [ByteW-1:0] pat_q;
  logic             act_q;
  logic [ByteW-1:0] win_q;

  // Pattern bytes carry no reset; the in-use flag guards them.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_shift) begin
      pat_q <= pat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      win_q <= '0;
    end else begin
      if (ctrl_i.act_clear) begin
        act_q <= 1'b0;
      end else if (ctrl_i.pat_shift) begin
        act_q <= act_i;
      end
      if (ctrl_i.win_clear) begin
        win_q <= '0;
      end else if (ctrl_i.win_shift) begin
        win_q <= win_i;
      end
    end
  end

  assign pat_o = pat_q;
  assign act_o = act_q;
  assign win_o = win_q;
  // An unused slot never blocks a match.
  assign hit_o = !act_q || (pat_q == win_q);

endmodule : fsmatch_cell

`default_nettype wire

// ===== sv/fsmatch_row.sv =====
// Row of comparator cells; bytes enter at the newest end and move one cell
// toward the oldest end per shift. Depends on fsmatch_pkg and fsmatch_cell.
`timescale 1ns / 1ps
`default_nettype none

module fsmatch_row (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire fsmatch_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]              byte_i,
  output logic                         match_o
);
  import fsmatch_pkg::*;

  logic [ByteW-1:0] pat_c [MaxPattern];
  logic             act_c [MaxPattern];
  logic [ByteW-1:0] win_c [MaxPattern];
  logic [MaxPattern-1:0] hit;

  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    logic [ByteW-1:0] pat_in;
    logic             act_in;
    logic [ByteW-1:0] win_in;

    if (j == MaxPattern - 1) begin : g_head
      assign pat_in = byte_i;
      assign act_in = 1'b1;
      assign win_in = byte_i;
    end else begin : g_link
      assign pat_in = pat_c[j+1];
      assign act_in = act_c[j+1];
      assign win_in = win_c[j+1];
    end

    fsmatch_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .pat_i  (pat_in),
      .act_i  (act_in),
      .win_i  (win_in),
      .pat_o  (pat_c[j]),
      .act_o  (act_c[j]),
      .win_o  (win_c[j]),
      .hit_o  (hit[j])
    );
  end

  assign match_o = &hit;

endmodule : fsmatch_row

`default_nettype wire

// ===== sv/first_substring_match_top.sv =====
// Top level of the streaming first-substring-match block: control sequencer,
// counters and output register. Depends on fsmatch_pkg and fsmatch_row.
//
//   Channel  | Direction | tdata              | tuser
//   s_axis   | in        | [7:0] data_byte    | [1:0] req_type
//   m_axis   | out       | [31:0] position    | [1:0] status
//
// Every input transfer is handled in two steps: the accept cycle updates the pattern
// row, the window row and the byte count, and the evaluation state that follows
// reduces the row's compare results and decides on a result.
// No new item is accepted until the evaluation of the last one is done.
// The evaluation cycle waits only when a new result meets a full output register
// that is not being drained; otherwise a waiting result does not hold up input.
// Reset is asynchronous and active low; it empties the pattern and the window
// at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module first_substring_match_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] position
  output logic [1:0]       m_axis_tuser_o    // [1:0] status
);
  import fsmatch_pkg::*;

  fsm_state_e state_q, state_d;

  req_type_e        kind_q;
  logic [LenW-1:0]  len_q;
  logic             ovf_q;
  logic [CountBits-1:0] count_q;
  logic             reported_q;

  logic             m_valid_q;
  logic [PosW-1:0]  m_pos_q;
  status_e          m_status_q;

  logic             in_xfer;
  logic             row_match;
  cell_ctrl_t       row_ctrl;

  // Evaluation results.
  logic             res_valid;
  status_e          res_status;
  logic [ExtW-1:0]  res_ext;
  logic [PosW-1:0]  res_pos;
  logic [ExtW-1:0]  count_ext;
  logic [ExtW-1:0]  len_ext;
  logic             eval_done;
  logic             out_load;

  req_type_e        in_kind;

  // Input is open whenever no item is being evaluated.
  assign s_axis_tready_o = (state_q == FSM_IDLE);

  assign in_kind   = req_type_e'(s_axis_tuser_i);
  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign count_ext = ExtW'(count_q);
  assign len_ext   = ExtW'(len_q);

  // The comparator row: one cell per pattern slot, newest byte at the top.
  fsmatch_row u_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (row_ctrl),
    .byte_i  (s_axis_tdata_i),
    .match_o (row_match)
  );

  // Decide on a result for the item held in evaluation.
  always_comb begin
    res_valid  = 1'b0;
    res_status = ST_FOUND;
    res_ext    = '0;
    unique case (kind_q)
      REQ_HAY: begin
        if (!reported_q && !ovf_q) begin
          if (len_q == '0) begin
            res_valid = 1'b1;
          end else if (count_ext >= len_ext && row_match) begin
            res_valid = 1'b1;
            res_ext   = count_ext - len_ext;
          end
        end
      end
      REQ_END: begin
        if (!reported_q) begin
          res_valid = 1'b1;
          if (ovf_q) begin
            res_status = ST_OVERFLOW;
            res_ext    = count_ext;
          end else if (len_q != '0) begin
            res_status = ST_NOTFOUND;
            res_ext    = count_ext;
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Positions beyond the 32-bit field saturate.
  assign res_pos = (res_ext > ExtW'({PosW{1'b1}})) ? {PosW{1'b1}} : res_ext[PosW-1:0];

  assign eval_done = (state_q == FSM_EVAL) &&
                     (!res_valid || !m_valid_q || m_axis_tready_i);
  assign out_load  = eval_done && res_valid;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_xfer) begin
          state_d = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        if (eval_done) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // Row-command logic.
  always_comb begin
    row_ctrl.pat_shift = 1'b0;
    row_ctrl.act_clear = 1'b0;
    row_ctrl.win_shift = 1'b0;
    row_ctrl.win_clear = 1'b0;
    if (in_xfer) begin
      row_ctrl.act_clear = (in_kind == REQ_CLEAR);
      row_ctrl.win_clear = (in_kind == REQ_CLEAR);
      row_ctrl.pat_shift = (in_kind == REQ_APPEND) && (len_q < LenW'(MaxPattern));
      row_ctrl.win_shift = (in_kind == REQ_HAY);
    end else if (eval_done && kind_q == REQ_END) begin
      // The end of a haystack restarts the window.
      row_ctrl.win_clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FSM_IDLE;
      kind_q     <= REQ_CLEAR;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      count_q    <= '0;
      reported_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        kind_q <= in_kind;
        unique case (in_kind)
          REQ_CLEAR: begin
            len_q      <= '0;
            ovf_q      <= 1'b0;
            count_q    <= '0;
            reported_q <= 1'b0;
          end
          REQ_APPEND: begin
            if (len_q < LenW'(MaxPattern)) begin
              len_q <= len_q + LenW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          REQ_HAY: begin
            if (count_q != {CountBits{1'b1}}) begin
              count_q <= count_q + CountBits'(1);
            end
          end
          REQ_END: begin
            count_q <= count_q;
          end
          default: begin
            count_q <= count_q;
          end
        endcase
      end else if (eval_done) begin
        if (kind_q == REQ_END) begin
          count_q    <= '0;
          reported_q <= 1'b0;
        end else if (res_valid) begin
          reported_q <= 1'b1;
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_pos_q    <= res_pos;
      m_status_q <= res_status;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_pos_q;
  assign m_axis_tuser_o  = m_status_q;

endmodule : first_substring_match_top

`default_nettype wire

// ===== sv/fsmatch_check.sv =====
// Port-level checker for first_substring_match_top, attached by bind.
// Depends on fsmatch_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module fsmatch_check (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);
  import fsmatch_pkg::*;

  // Every transfer in is followed by an evaluation state with input closed.
  a_eval_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input stayed open in the cycle after a transfer");

  // A new result only comes out of an evaluation cycle.
  a_result_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without an evaluation cycle");

  // A held result keeps its payload.
  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_FOUND || m_axis_tuser_o == ST_NOTFOUND ||
                         m_axis_tuser_o == ST_OVERFLOW))
    else $error("undefined status code on output");

endmodule : fsmatch_check

bind first_substring_match_top fsmatch_check u_fsmatch_check (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// ===== verif/first_substring_match_top_tb.sv =====
// Self-checking testbench for first_substring_match_top: a directed table and random
// pattern/haystack episodes, each result checked against a predictor held in the bench or a result given in the table.
// Depends on fsmatch_pkg and the RTL of the block.
`timescale 1ns / 1ps

module first_substring_match_top_tb;
  import fsmatch_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int LongHold      = 400;
  localparam int RandomItems   = 1700;
  localparam int QuietFrom     = 1500;
  localparam int NumRows       = 33;

  typedef struct packed {
    status_e          status;
    logic [PosW-1:0]  position;
  } report_t;

  typedef struct packed {
    req_type_e        kind;
    logic [ByteW-1:0] data;
    logic [7:0]       reps;
    logic             given;     // expected result typed in below
    status_e          status;
    logic [PosW-1:0]  position;
  } stim_row_t;

  // Hand-checked opening sequence. Rows with the given bit carry a result that can
  // be read off directly; all others rely on the predictor.
  localparam stim_row_t DirectedRows [NumRows] = '{
    // Empty pattern: first haystack byte is found at 0, later bytes are quiet.
    '{REQ_HAY,    8'h00, 8'd1,  1'b1, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'hFF, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_END,    8'h5A, 8'd1,  1'b0, ST_FOUND,    32'd0},
    // Empty pattern and empty haystack report found at 0 on the end item.
    '{REQ_END,    8'hA5, 8'd1,  1'b1, ST_FOUND,    32'd0},
    // Pattern of two zero bytes: the zeroed window must not match too early.
    '{REQ_APPEND, 8'h00, 8'd2,  1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'h00, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'h00, 8'd1,  1'b1, ST_FOUND,    32'd0},
    '{REQ_END,    8'h00, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_END,    8'hFF, 8'd1,  1'b1, ST_NOTFOUND, 32'd0},
    '{REQ_CLEAR,  8'h3C, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_APPEND, 8'hFF, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_APPEND, 8'hA5, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'h12, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'hFF, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'hA5, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'hFF, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_END,    8'h00, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'h5A, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_END,    8'h00, 8'd1,  1'b1, ST_NOTFOUND, 32'd1},
    // The pattern grows in the middle of a haystack.
    '{REQ_HAY,    8'hFF, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_APPEND, 8'h3C, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'hA5, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'h3C, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_END,    8'hC3, 8'd1,  1'b0, ST_FOUND,    32'd0},
    // One byte past capacity sets the overflow flag; the end item reports it.
    '{REQ_CLEAR,  8'hFF, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_APPEND, 8'h77, 8'd65, 1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'h77, 8'd3,  1'b0, ST_FOUND,    32'd0},
    '{REQ_END,    8'h81, 8'd1,  1'b1, ST_OVERFLOW, 32'd3},
    // A full-capacity pattern of zeros matches only once 64 bytes were seen.
    '{REQ_CLEAR,  8'h00, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_APPEND, 8'h00, 8'd64, 1'b0, ST_FOUND,    32'd0},
    '{REQ_HAY,    8'h00, 8'd64, 1'b0, ST_FOUND,    32'd0},
    '{REQ_END,    8'h7E, 8'd1,  1'b0, ST_FOUND,    32'd0},
    '{REQ_CLEAR,  8'h42, 8'd1,  1'b0, ST_FOUND,    32'd0}
  };

  logic             clk_i;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic [ByteW-1:0] in_data   = '0;
  req_type_e        in_kind   = REQ_CLEAR;
  logic             out_ready = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [PosW-1:0]  m_axis_tdata_o;
  logic [1:0]       m_axis_tuser_o;

  // Predictor state: pattern, recent haystack bytes, byte count and report flag.
  logic [ByteW-1:0]     pat_mem [MaxPattern];
  int unsigned          pat_len;
  bit                   pat_ovf;
  logic [ByteW-1:0]     hay_win [MaxPattern];
  logic [CountBits-1:0] hay_count;
  bit                   hay_done;

  report_t pending_reports [$];

  int  errors;
  int  items_sent;
  int  reports_checked;
  int  status_seen [3];
  int  input_stalls;
  int  idle_cycles;
  bit  quiet;
  bit  sender_calm;
  bit  rx_calm;
  bit  long_hold_req;

  first_substring_match_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_kind),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void restart_haystack();
    for (int k = 0; k < MaxPattern; k++) hay_win[k] = '0;
    hay_count = '0;
    hay_done  = 1'b0;
  endfunction

  // Positions saturate at the largest value of the position field.
  function automatic logic [PosW-1:0] clip_pos(input logic [ExtW-1:0] v);
    if (v > ExtW'({PosW{1'b1}})) return '1;
    return v[PosW-1:0];
  endfunction

  // Advances the predictor by one accepted item; returns 1 when a result is due.
  function automatic bit predict_match(input req_type_e kind, input logic [ByteW-1:0] b,
                                       output status_e st, output logic [PosW-1:0] pos);
    bit hit;
    int unsigned base;
    st  = ST_FOUND;
    pos = '0;
    case (kind)
      REQ_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        restart_haystack();
        return 1'b0;
      end
      REQ_APPEND: begin
        if (pat_len < MaxPattern) begin
          pat_mem[pat_len] = b;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        return 1'b0;
      end
      REQ_HAY: begin
        for (int k = 0; k < MaxPattern - 1; k++) hay_win[k] = hay_win[k + 1];
        hay_win[MaxPattern - 1] = b;
        if (hay_count != '1) hay_count++;
        if (hay_done || pat_ovf) return 1'b0;
        if (pat_len == 0) begin
          hay_done = 1'b1;
          return 1'b1;
        end
        // Nothing is compared while the haystack is shorter than the pattern.
        if (ExtW'(hay_count) < ExtW'(pat_len)) return 1'b0;
        hit  = 1'b1;
        base = MaxPattern - pat_len;
        for (int k = 0; k < pat_len; k++) begin
          if (hay_win[base + k] != pat_mem[k]) hit = 1'b0;
        end
        if (!hit) return 1'b0;
        hay_done = 1'b1;
        pos      = clip_pos(ExtW'(hay_count) - ExtW'(pat_len));
        return 1'b1;
      end
      default: begin
        hit = !hay_done;
        if (pat_ovf) begin
          st  = ST_OVERFLOW;
          pos = clip_pos(ExtW'(hay_count));
        end else if (pat_len != 0) begin
          st  = ST_NOTFOUND;
          pos = clip_pos(ExtW'(hay_count));
        end
        restart_haystack();
        return hit;
      end
    endcase
  endfunction

  // Offers one item, waits for its transfer and records what it should produce.
  task automatic send_item(input req_type_e kind, input logic [ByteW-1:0] b,
                           input bit given = 1'b0, input status_e given_st = ST_FOUND,
                           input logic [PosW-1:0] given_pos = '0);
    report_t exp_rep;
    bit      due;
    if (!quiet && !sender_calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_data  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    due = predict_match(kind, b, exp_rep.status, exp_rep.position);
    if (given) begin
      exp_rep.status   = given_st;
      exp_rep.position = given_pos;
    end
    if (due || given) pending_reports.push_back(exp_rep);
    items_sent++;
  endtask

  function automatic logic [ByteW-1:0] pick_byte(input logic [ByteW-1:0] alpha [4]);
    if ($urandom_range(0, 4) == 0) return ByteW'($urandom_range(0, 255));
    return alpha[$urandom_range(0, 3)];
  endfunction

  // One random episode: usually a fresh pattern over a small alphabet, then a
  // haystack that often carries the pattern somewhere, then the end item.
  task automatic run_episode();
    int               mode;
    int               plen;
    int               hlen;
    int               off;
    bit               plant;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] alpha [4];
    logic [ByteW-1:0] pat [$];
    for (int k = 0; k < 4; k++) alpha[k] = ByteW'($urandom_range(0, 255));
    sender_calm = ($urandom_range(0, 3) == 0);
    mode = $urandom_range(0, 99);
    if (mode < 5) begin
      repeat (12) send_item(req_type_e'($urandom_range(0, 3)), ByteW'($urandom_range(0, 255)));
      return;
    end
    // Modes 5 to 11 keep whatever pattern is in place.
    if (mode >= 12) begin
      send_item(REQ_CLEAR, ByteW'($urandom_range(0, 255)));
      if (mode < 20) plen = 0;
      else if (mode < 26) plen = $urandom_range(7, MaxPattern);
      else if (mode < 30) plen = $urandom_range(MaxPattern + 1, MaxPattern + 4);
      else plen = $urandom_range(1, 6);
      for (int k = 0; k < plen; k++) begin
        b = pick_byte(alpha);
        pat.push_back(b);
        send_item(REQ_APPEND, b);
      end
    end
    hlen  = $urandom_range(0, 24) + pat.size();
    plant = (pat.size() != 0) && ($urandom_range(0, 1) == 1);
    off   = plant ? $urandom_range(0, hlen - pat.size()) : 0;
    for (int k = 0; k < hlen; k++) begin
      if (plant && k >= off && k < off + pat.size()) b = pat[k - off];
      else b = pick_byte(alpha);
      send_item(REQ_HAY, b);
      if ($urandom_range(0, 39) == 0) send_item(REQ_APPEND, pick_byte(alpha));
    end
    // Now and then the haystack runs on into the next episode.
    if ($urandom_range(0, 9) != 0) send_item(REQ_END, ByteW'($urandom_range(0, 255)));
  endtask

  // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!quiet && !rx_calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Result checker: every result transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    report_t exp_rep;
    if (rst_ni && in_valid && !s_axis_tready_o) input_stalls++;
    if (rst_ni && m_axis_tvalid_o && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: status %0d, position %0d", m_axis_tuser_o, m_axis_tdata_o);
        errors++;
      end else begin
        exp_rep = pending_reports.pop_front();
        reports_checked++;
        if (m_axis_tuser_o < 3) status_seen[m_axis_tuser_o]++;
        if (m_axis_tuser_o != exp_rep.status) begin
          $error("status: expected %0d, actual %0d", exp_rep.status, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o != exp_rep.position) begin
          $error("position: expected %0d, actual %0d", exp_rep.position, m_axis_tdata_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid && s_axis_tready_o) || (m_axis_tvalid_o && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired with %0d results outstanding.", pending_reports.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    pat_len = 0;
    pat_ovf = 1'b0;
    restart_haystack();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      repeat (DirectedRows[i].reps) begin
        send_item(DirectedRows[i].kind, DirectedRows[i].data, DirectedRows[i].given,
                  DirectedRows[i].status, DirectedRows[i].position);
      end
    end

    // With an empty pattern every end item yields a result, so a long hold-off
    // on the result side fills the block and must back-pressure the input.
    long_hold_req = 1'b1;
    repeat (30) send_item(REQ_END, ByteW'($urandom_range(0, 255)));

    while (items_sent < RandomItems) begin
      if (items_sent >= QuietFrom) quiet = 1'b1;
      run_episode();
    end
    send_item(REQ_END, ByteW'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d input transfers and checked %0d results", items_sent, reports_checked);
    $display("(%0d found, %0d not found, %0d overflow).", status_seen[ST_FOUND],
             status_seen[ST_NOTFOUND], status_seen[ST_OVERFLOW]);
    $display("Input was held off for %0d cycles; %0d mismatches were seen.", input_stalls, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fsmatch_pkg.sv
sv/fsmatch_cell.sv
sv/fsmatch_row.sv
sv/first_substring_match_top.sv
sv/fsmatch_check.sv
verif/first_substring_match_top_tb.sv
